/* rtl/pgs_pkg.sv */
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared constants, datapath op codes and status type for the path
// gradient smoother.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int PT_W       = 2 * COORD_W;
    localparam int ERR_W      = 48;
    localparam int WGT_W      = 16;
    localparam int TOL_W      = 32;
    localparam int SWP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT    = 2'd3;

    // configuration reset values
    localparam logic [WGT_W-1:0] DATA_WEIGHT_RST    = 16'd32768;
    localparam logic [WGT_W-1:0] SMOOTH_WEIGHT_RST  = 16'd6554;
    localparam logic [TOL_W-1:0] STOP_TOLERANCE_RST = 32'd66;
    localparam logic [SWP_W-1:0] SWEEP_LIMIT_RST    = 16'd1000;

    // datapath commands
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE        = 5'd0;
    localparam op_t OP_LOAD        = 5'd1;
    localparam op_t OP_SMOOTH_INIT = 5'd2;
    localparam op_t OP_SWEEP_START = 5'd3;
    localparam op_t OP_PRIME0      = 5'd4;
    localparam op_t OP_PRIME1      = 5'd5;
    localparam op_t OP_PRIME2      = 5'd6;
    localparam op_t OP_FETCH       = 5'd7;
    localparam op_t OP_DIFF        = 5'd8;
    localparam op_t OP_MUL         = 5'd9;
    localparam op_t OP_RND         = 5'd10;
    localparam op_t OP_UPD         = 5'd11;
    localparam op_t OP_SQ          = 5'd12;
    localparam op_t OP_SUM         = 5'd13;
    localparam op_t OP_ACC         = 5'd14;
    localparam op_t OP_EMIT_START  = 5'd15;
    localparam op_t OP_EMIT_LD     = 5'd16;
    localparam op_t OP_EMIT_NEXT   = 5'd17;
    localparam op_t OP_EMIT_DONE   = 5'd18;

    typedef struct packed {
        logic stop;           // no further sweep: limit reached or converged
        logic long_path;      // path ending now has three or more points
        logic last_interior;  // current point is the last interior one
        logic out_taken;      // output item handed over this cycle
        logic out_is_last;    // output register holds the final point
    } status_t;

endpackage

/* rtl/path_gradient_smoother_top.sv */
// ----------------------------------------------------------------------------
// path_gradient_smoother_top
// Gauss-Seidel gradient smoothing of a streamed path of Q16.16 points.
// ----------------------------------------------------------------------------
// Points load at one item per cycle until an item with last_point set. A path
// of three or more points is then smoothed in place: each sweep primes the
// window, then updates interior points in turn, as every update runs through
// one shared update datapath (read neighbor, difference, multiply, round,
// write back, square, sum, accumulate) and the next point needs the point just
// written. Sweeps repeat until the error change drops below stop_tolerance or
// sweep_limit sweeps have run, after which the convergence check leads to
// emission. Each point passes read, load and wait states (wait on out_ready),
// paced by the single registered read port of the working store. Input
// is held off (in_ready low) from the final item until the last point has been
// taken. Points beyond 64 are dropped, but their last_point still ends the
// path. Paths of one or two points, or a zero sweep_limit, pass through
// unchanged. Configuration writes take effect at once and are meant for idle.
// ----------------------------------------------------------------------------
module path_gradient_smoother_top import pgs_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // input points
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic                      last_point,
    // smoothed points
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic                      out_last
);

    logic [WGT_W-1:0] data_weight_reg;
    logic [WGT_W-1:0] smooth_weight_reg;
    logic [TOL_W-1:0] stop_tolerance_reg;
    logic [SWP_W-1:0] sweep_limit_reg;

    op_t     op;
    status_t st;

    // configuration registers; writes land at once, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_weight_reg    <= DATA_WEIGHT_RST;
            smooth_weight_reg  <= SMOOTH_WEIGHT_RST;
            stop_tolerance_reg <= STOP_TOLERANCE_RST;
            sweep_limit_reg    <= SWEEP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DATA_WEIGHT:    data_weight_reg    <= cfg_data[WGT_W-1:0];
                REG_SMOOTH_WEIGHT:  smooth_weight_reg  <= cfg_data[WGT_W-1:0];
                REG_STOP_TOLERANCE: stop_tolerance_reg <= cfg_data[TOL_W-1:0];
                REG_SWEEP_LIMIT:    sweep_limit_reg    <= cfg_data[SWP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequence control: one command per cycle to the datapath
    pgs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .st         (st),
        .in_ready   (in_ready),
        .op         (op)
    );

    // stores, arithmetic and output register
    pgs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .point_x        (point_x),
        .point_y        (point_y),
        .data_weight    (data_weight_reg),
        .smooth_weight  (smooth_weight_reg),
        .stop_tolerance (stop_tolerance_reg),
        .sweep_limit    (sweep_limit_reg),
        .st             (st),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_last       (out_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result item is pending");

    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("input not reopened after final item");

endmodule

/* rtl/pgs_ram.sv */
// ----------------------------------------------------------------------------
// pgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pgs_dp.sv */
// ----------------------------------------------------------------------------
// pgs_dp
// Datapath: point stores, neighbor window, update arithmetic, error
// accumulation, convergence test and output register.
// ----------------------------------------------------------------------------
module pgs_dp import pgs_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  op_t                       op,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [WGT_W-1:0]          data_weight,
    input  logic [WGT_W-1:0]          smooth_weight,
    input  logic [TOL_W-1:0]          stop_tolerance,
    input  logic [SWP_W-1:0]          sweep_limit,
    output status_t                   st,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic                      out_last,
    output logic                      out_valid,
    input  logic                      out_ready
);

    // control state
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             first_reg;
    logic [SWP_W-1:0] sweep_reg;
    logic [ERR_W-1:0] prev_err_reg;
    logic [ERR_W-1:0] cur_err_reg;
    logic             out_valid_reg;

    // payload pipeline, one lane per coordinate (0 = x, 1 = y)
    logic signed [COORD_W-1:0] prev_reg [2];
    logic signed [COORD_W-1:0] cur_reg  [2];
    logic signed [COORD_W-1:0] nxt_reg  [2];
    logic signed [32:0]        od_reg   [2];
    logic signed [34:0]        nb_reg   [2];
    logic signed [49:0]        p1_reg   [2];
    logic signed [51:0]        p2_reg   [2];
    logic signed [34:0]        d1_reg   [2];
    logic signed [36:0]        d2_reg   [2];
    logic [31:0]               a1_reg   [2];
    logic [31:0]               a2_reg   [2];
    logic                      ov1_reg  [2];
    logic                      ov2_reg  [2];
    logic [ERR_W-1:0]          t1_reg   [2];
    logic [ERR_W-1:0]          t2_reg   [2];
    logic [ERR_W:0]            s_reg    [2];
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic                      out_last_reg;

    // combinational
    logic                      full;
    logic                      load_we;
    logic [PT_W-1:0]           orig_rdata;
    logic [PT_W-1:0]           work_rdata;
    logic                      work_we;
    logic [IDX_W-1:0]          work_waddr;
    logic [PT_W-1:0]           work_wdata;
    logic [IDX_W-1:0]          work_raddr;
    logic signed [COORD_W-1:0] rd_w     [2];
    logic signed [COORD_W-1:0] rd_o     [2];
    logic signed [32:0]        od_c     [2];
    logic signed [34:0]        nb_c     [2];
    logic signed [49:0]        p1_c     [2];
    logic signed [51:0]        p2_c     [2];
    logic signed [50:0]        r1_c     [2];
    logic signed [52:0]        r2_c     [2];
    logic signed [COORD_W-1:0] wn_c     [2];
    logic signed [34:0]        a1_c     [2];
    logic signed [36:0]        a2_c     [2];
    logic [63:0]               sq1_c    [2];
    logic [63:0]               sq2_c    [2];
    logic [ERR_W+2:0]          tot_c;
    logic [ERR_W-1:0]          acc_c;
    logic [ERR_W-1:0]          diff_c;
    logic                      last_int;

    assign full    = (count_reg == CNT_W'(MAX_POINTS));
    assign load_we = (op == OP_LOAD) && !full;

    // stores: original points written only on load, working points on load
    // and on each interior update
    pgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_orig (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({point_y, point_x}),
        .raddr (idx_reg),
        .rdata (orig_rdata)
    );

    assign work_we    = load_we || (op == OP_UPD);
    assign work_waddr = (op == OP_UPD) ? idx_reg : count_reg[IDX_W-1:0];
    assign work_wdata = (op == OP_UPD) ? {wn_c[1], wn_c[0]} : {point_y, point_x};
    assign work_raddr = (op == OP_FETCH) ? idx_reg + IDX_W'(1) : idx_reg;

    pgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_work (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rd_w[k]  = work_rdata[k*COORD_W +: COORD_W];
            rd_o[k]  = orig_rdata[k*COORD_W +: COORD_W];
            od_c[k]  = 33'(rd_o[k]) - 33'(cur_reg[k]);
            nb_c[k]  = 35'(rd_w[k]) + 35'(prev_reg[k]) - (35'(cur_reg[k]) <<< 1);
            p1_c[k]  = $signed({1'b0, data_weight}) * od_reg[k];
            p2_c[k]  = $signed({1'b0, smooth_weight}) * nb_reg[k];
            // round half up, then arithmetic shift by 16
            r1_c[k]  = 51'(p1_reg[k]) + 51'sd32768;
            r2_c[k]  = 53'(p2_reg[k]) + 53'sd32768;
            wn_c[k]  = cur_reg[k] + d1_reg[k][COORD_W-1:0] + d2_reg[k][COORD_W-1:0];
            a1_c[k]  = d1_reg[k][34] ? -d1_reg[k] : d1_reg[k];
            a2_c[k]  = d2_reg[k][36] ? -d2_reg[k] : d2_reg[k];
            sq1_c[k] = a1_reg[k] * a1_reg[k];
            sq2_c[k] = a2_reg[k] * a2_reg[k];
        end
        tot_c  = {2'b00, cur_err_reg} + {1'b0, s_reg[0]} + {1'b0, s_reg[1]};
        acc_c  = (tot_c > {3'b000, ERR_MAX}) ? ERR_MAX : tot_c[ERR_W-1:0];
        diff_c = (prev_err_reg > cur_err_reg) ? prev_err_reg - cur_err_reg
                                              : cur_err_reg - prev_err_reg;
    end

    assign last_int = ({1'b0, idx_reg} == count_reg - CNT_W'(2));

    always_comb
    begin
        st.stop          = (sweep_reg >= sweep_limit) ||
                           (!first_reg && (diff_c < {{(ERR_W-TOL_W){1'b0}}, stop_tolerance}));
        st.long_path     = (count_reg >= CNT_W'(2));
        st.last_interior = last_int;
        st.out_taken     = out_valid_reg && out_ready;
        st.out_is_last   = out_last_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b1;
            sweep_reg     <= '0;
            prev_err_reg  <= '0;
            cur_err_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_LOAD:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                OP_SMOOTH_INIT:
                begin
                    prev_err_reg <= '0;
                    cur_err_reg  <= '0;
                    sweep_reg    <= '0;
                    first_reg    <= 1'b1;
                end
                OP_SWEEP_START:
                begin
                    prev_err_reg <= cur_err_reg;
                    cur_err_reg  <= '0;
                    first_reg    <= 1'b0;
                    idx_reg      <= '0;
                end
                OP_PRIME0:
                begin
                    idx_reg <= IDX_W'(1);
                end
                OP_ACC:
                begin
                    cur_err_reg <= acc_c;
                    idx_reg     <= idx_reg + IDX_W'(1);
                    if (last_int)
                    begin
                        sweep_reg <= sweep_reg + SWP_W'(1);
                    end
                end
                OP_EMIT_START:
                begin
                    idx_reg <= '0;
                end
                OP_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                end
                OP_EMIT_NEXT:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                OP_EMIT_DONE:
                begin
                    idx_reg   <= '0;
                    count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_PRIME1:
            begin
                for (int k = 0; k < 2; k++) prev_reg[k] <= rd_w[k];
            end
            OP_PRIME2:
            begin
                for (int k = 0; k < 2; k++) cur_reg[k] <= rd_w[k];
            end
            OP_DIFF:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    nxt_reg[k] <= rd_w[k];
                    od_reg[k]  <= od_c[k];
                    nb_reg[k]  <= nb_c[k];
                end
            end
            OP_MUL:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    p1_reg[k] <= p1_c[k];
                    p2_reg[k] <= p2_c[k];
                end
            end
            OP_RND:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    d1_reg[k] <= r1_c[k][50:16];
                    d2_reg[k] <= r2_c[k][52:16];
                end
            end
            OP_UPD:
            begin
                // slide the window: updated point becomes the left neighbor
                for (int k = 0; k < 2; k++)
                begin
                    prev_reg[k] <= wn_c[k];
                    cur_reg[k]  <= nxt_reg[k];
                    a1_reg[k]   <= a1_c[k][31:0];
                    a2_reg[k]   <= a2_c[k][31:0];
                    ov1_reg[k]  <= |a1_c[k][34:32];
                    ov2_reg[k]  <= |a2_c[k][36:32];
                end
            end
            OP_SQ:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    t1_reg[k] <= ov1_reg[k] ? ERR_MAX : sq1_c[k][63:16];
                    t2_reg[k] <= ov2_reg[k] ? ERR_MAX : sq2_c[k][63:16];
                end
            end
            OP_SUM:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    s_reg[k] <= {1'b0, t1_reg[k]} + {1'b0, t2_reg[k]};
                end
            end
            OP_EMIT_LD:
            begin
                out_x_reg    <= rd_w[0];
                out_y_reg    <= rd_w[1];
                out_last_reg <= ({1'b0, idx_reg} == count_reg - CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ACC) |=> (cur_err_reg >= $past(cur_err_reg)))
        else $error("error accumulator decreased within a sweep");

    a_fetch_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_FETCH) |-> ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg))
        else $error("neighbor fetch beyond loaded points");

endmodule

/* rtl/pgs_ctrl.sv */
// ----------------------------------------------------------------------------
// pgs_ctrl
// Controller: sequences load, sweeps, per-point update steps and emission.
// ----------------------------------------------------------------------------
module pgs_ctrl import pgs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    last_point,
    input  status_t st,
    output logic    in_ready,
    output op_t     op
);

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_INIT   = 5'd1;
    localparam logic [4:0] ST_CHECK  = 5'd2;
    localparam logic [4:0] ST_PRIME0 = 5'd3;
    localparam logic [4:0] ST_PRIME1 = 5'd4;
    localparam logic [4:0] ST_PRIME2 = 5'd5;
    localparam logic [4:0] ST_FETCH  = 5'd6;
    localparam logic [4:0] ST_DIFF   = 5'd7;
    localparam logic [4:0] ST_MUL    = 5'd8;
    localparam logic [4:0] ST_RND    = 5'd9;
    localparam logic [4:0] ST_UPD    = 5'd10;
    localparam logic [4:0] ST_SQ     = 5'd11;
    localparam logic [4:0] ST_SUM    = 5'd12;
    localparam logic [4:0] ST_ACC    = 5'd13;
    localparam logic [4:0] ST_ESTART = 5'd14;
    localparam logic [4:0] ST_ERD    = 5'd15;
    localparam logic [4:0] ST_ELD    = 5'd16;
    localparam logic [4:0] ST_EWAIT  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (last_point)
                    begin
                        state_next = st.long_path ? ST_INIT : ST_ESTART;
                    end
                end
            end
            ST_INIT:
            begin
                op         = OP_SMOOTH_INIT;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (st.stop)
                begin
                    op         = OP_EMIT_START;
                    state_next = ST_ERD;
                end
                else
                begin
                    op         = OP_SWEEP_START;
                    state_next = ST_PRIME0;
                end
            end
            ST_PRIME0:
            begin
                op         = OP_PRIME0;
                state_next = ST_PRIME1;
            end
            ST_PRIME1:
            begin
                op         = OP_PRIME1;
                state_next = ST_PRIME2;
            end
            ST_PRIME2:
            begin
                op         = OP_PRIME2;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                op         = OP_FETCH;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                op         = OP_DIFF;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                op         = OP_MUL;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                op         = OP_RND;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                op         = OP_UPD;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                op         = OP_SQ;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                op         = OP_SUM;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                op         = OP_ACC;
                state_next = st.last_interior ? ST_CHECK : ST_FETCH;
            end
            ST_ESTART:
            begin
                op         = OP_EMIT_START;
                state_next = ST_ERD;
            end
            ST_ERD:
            begin
                // working store read address follows the index
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                op         = OP_EMIT_LD;
                state_next = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                if (st.out_taken)
                begin
                    if (st.out_is_last)
                    begin
                        op         = OP_EMIT_DONE;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        op         = OP_EMIT_NEXT;
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
